// File: rtl/spectral_matrix_transform_assert.svh
// Assertion macros used by the checker file.
`ifndef SPECTRAL_MATRIX_TRANSFORM_ASSERT_SVH
`define SPECTRAL_MATRIX_TRANSFORM_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define SMT_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define SMT_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/smt_pkg.sv
`timescale 1ns / 1ps

package smt_pkg;

   localparam int BANDS    = 4;
   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 16;
   localparam int ROW_W    = BANDS * COEF_W;
   localparam int RES_W    = 22;
   localparam int FRAC_W   = 12;
   localparam int PROD_W   = COEF_W + SAMPLE_W + 1;
   localparam int SUM_W    = PROD_W + $clog2(BANDS) + 1;
   localparam int CSR_IDX_W = 3;

   localparam int ONE_Q12   = 1 << FRAC_W;
   localparam int HALF_Q12  = ONE_Q12 / 2;
   localparam int FRAC_MASK = ONE_Q12 - 1;
   localparam int RES_MAX   = (1 << (RES_W - 1)) - 1;
   localparam int RES_MIN   = -(1 << (RES_W - 1));

   typedef logic        [SAMPLE_W-1:0] sample_type;
   typedef logic signed [COEF_W-1:0]   coef_type;
   typedef logic        [ROW_W-1:0]    row_type;
   typedef logic signed [PROD_W-1:0]   prod_type;
   typedef logic signed [SUM_W-1:0]    sum_type;
   typedef logic signed [RES_W-1:0]    res_type;

   localparam res_type RES_MAX_V = res_type'(RES_MAX);
   localparam res_type RES_MIN_V = res_type'(RES_MIN);

   typedef enum logic [CSR_IDX_W-1:0] {
      MATRIX_ROW_0 = 3'd0,
      MATRIX_ROW_1 = 3'd1,
      MATRIX_ROW_2 = 3'd2,
      MATRIX_ROW_3 = 3'd3
   } csr_index_type;

   typedef struct packed {
      logic load_s1;
      logic load_s2;
   } lane_ctrl_type;

   typedef struct packed {
      logic load;
      logic frame_start;
   } stat_ctrl_type;

endpackage

// File: rtl/smt_lane.sv
`timescale 1ns / 1ps

module smt_lane (
   input  logic                  clock,
   input  smt_pkg::lane_ctrl_type ctrl,
   input  smt_pkg::row_type      coef_row,
   input  smt_pkg::sample_type   sample [smt_pkg::BANDS],
   output smt_pkg::res_type      result
);
   import smt_pkg::*;

   prod_type prod_ff [BANDS];
   prod_type prod_in [BANDS];
   res_type  result_ff;
   res_type  result_in;
   sum_type  sum;
   sum_type  biased;
   sum_type  quot;

   always_comb begin
      for (int k = 0; k < BANDS; k++) begin
         prod_in[k] = prod_type'(coef_type'(coef_row[k*COEF_W +: COEF_W]))
                    * prod_type'($signed({1'b0, sample[k]}));
      end
   end

   // add one half, divide by 4096 truncating toward zero, then saturate to the result range
   always_comb begin
      sum = sum_type'(HALF_Q12);
      for (int k = 0; k < BANDS; k++) begin
         sum = sum + sum_type'(prod_ff[k]);
      end
      biased = sum[SUM_W-1] ? sum + sum_type'(FRAC_MASK) : sum;
      quot   = biased >>> FRAC_W;
      if (quot > sum_type'(RES_MAX)) begin
         result_in = RES_MAX_V;
      end else if (quot < sum_type'(RES_MIN)) begin
         result_in = RES_MIN_V;
      end else begin
         result_in = res_type'(quot);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_s1) begin
         prod_ff <= prod_in;
      end
      if (ctrl.load_s2) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

// File: rtl/smt_merge.sv
`timescale 1ns / 1ps

module smt_merge (
   input  logic                  clock,
   input  logic                  reset,
   input  smt_pkg::stat_ctrl_type ctrl,
   input  smt_pkg::res_type      lane_result [smt_pkg::BANDS],
   output smt_pkg::res_type      result      [smt_pkg::BANDS],
   output smt_pkg::res_type      minimum     [smt_pkg::BANDS],
   output smt_pkg::res_type      maximum     [smt_pkg::BANDS]
);
   import smt_pkg::*;

   res_type result_ff [BANDS];
   res_type min_ff    [BANDS];
   res_type max_ff    [BANDS];
   res_type min_in    [BANDS];
   res_type max_in    [BANDS];
   res_type base_min  [BANDS];
   res_type base_max  [BANDS];

   // frame start drops the old statistics before this pixel counts
   always_comb begin
      for (int j = 0; j < BANDS; j++) begin
         base_min[j] = ctrl.frame_start ? RES_MAX_V : min_ff[j];
         base_max[j] = ctrl.frame_start ? RES_MIN_V : max_ff[j];
         min_in[j]   = (lane_result[j] < base_min[j]) ? lane_result[j] : base_min[j];
         max_in[j]   = (lane_result[j] > base_max[j]) ? lane_result[j] : base_max[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < BANDS; j++) begin
            min_ff[j] <= RES_MAX_V;
            max_ff[j] <= RES_MIN_V;
         end
      end else if (ctrl.load) begin
         min_ff <= min_in;
         max_ff <= max_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         result_ff <= lane_result;
      end
   end

   assign result  = result_ff;
   assign minimum = min_ff;
   assign maximum = max_ff;

endmodule

// File: rtl/spectral_matrix_transform.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   sample_0..3, frame_start
// rsp_      out        rsp_valid/rsp_stall   result_0..3, minimum_0..3, maximum_0..3
// csr_      in         csr_write_enable      csr_index, csr_write_data
//
// One pixel per cycle sustained while the result side does not stall; the stages are:
// products (16 multipliers, one lane per output band), round and saturate,
// then the statistics compare that also loads the output register.
// Reset clears stage valids and statistics and loads the identity matrix.
// A stall on the result side fills empty stages first; req_stall rises only
// when every stage holds a pixel.

module spectral_matrix_transform (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  smt_pkg::sample_type           req_sample_0,
   input  smt_pkg::sample_type           req_sample_1,
   input  smt_pkg::sample_type           req_sample_2,
   input  smt_pkg::sample_type           req_sample_3,
   input  logic                          req_frame_start,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output smt_pkg::res_type              rsp_result_0,
   output smt_pkg::res_type              rsp_result_1,
   output smt_pkg::res_type              rsp_result_2,
   output smt_pkg::res_type              rsp_result_3,
   output smt_pkg::res_type              rsp_minimum_0,
   output smt_pkg::res_type              rsp_minimum_1,
   output smt_pkg::res_type              rsp_minimum_2,
   output smt_pkg::res_type              rsp_minimum_3,
   output smt_pkg::res_type              rsp_maximum_0,
   output smt_pkg::res_type              rsp_maximum_1,
   output smt_pkg::res_type              rsp_maximum_2,
   output smt_pkg::res_type              rsp_maximum_3,
   input  logic                          csr_write_enable,
   input  logic [smt_pkg::CSR_IDX_W-1:0] csr_index,
   input  smt_pkg::row_type              csr_write_data
);
   import smt_pkg::*;

   row_type       row_ff [BANDS];
   logic          v1_ff, v2_ff, v3_ff;
   logic          v1_in, v2_in, v3_in;
   logic          fs1_ff, fs2_ff;
   logic          ready1, ready2, ready3;
   sample_type    samples     [BANDS];
   res_type       lane_result [BANDS];
   res_type       result      [BANDS];
   res_type       minimum     [BANDS];
   res_type       maximum     [BANDS];
   lane_ctrl_type lane_ctrl;
   stat_ctrl_type stat_ctrl;

   assign samples[0] = req_sample_0;
   assign samples[1] = req_sample_1;
   assign samples[2] = req_sample_2;
   assign samples[3] = req_sample_3;

   // a stage advances when it is empty or its successor advances
   always_comb begin
      ready3 = !v3_ff || !rsp_stall;
      ready2 = !v2_ff || ready3;
      ready1 = !v1_ff || ready2;
      v1_in  = ready1 ? req_valid : v1_ff;
      v2_in  = ready2 ? v1_ff : v2_ff;
      v3_in  = ready3 ? v2_ff : v3_ff;
      lane_ctrl.load_s1     = ready1 && req_valid;
      lane_ctrl.load_s2     = ready2 && v1_ff;
      stat_ctrl.load        = ready3 && v2_ff;
      stat_ctrl.frame_start = fs2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (lane_ctrl.load_s1) begin
         fs1_ff <= req_frame_start;
      end
      if (lane_ctrl.load_s2) begin
         fs2_ff <= fs1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < BANDS; j++) begin
            row_ff[j] <= row_type'(ONE_Q12) << (j * COEF_W);
         end
      end else if (csr_write_enable) begin
         case (csr_index)
            MATRIX_ROW_0: row_ff[0] <= csr_write_data;
            MATRIX_ROW_1: row_ff[1] <= csr_write_data;
            MATRIX_ROW_2: row_ff[2] <= csr_write_data;
            MATRIX_ROW_3: row_ff[3] <= csr_write_data;
            default: ;
         endcase
      end
   end

   for (genvar j = 0; j < BANDS; j++) begin : g_lane
      smt_lane u_lane (
         .clock    (clock),
         .ctrl     (lane_ctrl),
         .coef_row (row_ff[j]),
         .sample   (samples),
         .result   (lane_result[j])
      );
   end

   smt_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (stat_ctrl),
      .lane_result (lane_result),
      .result      (result),
      .minimum     (minimum),
      .maximum     (maximum)
   );

   assign req_stall     = !ready1;
   assign rsp_valid     = v3_ff;
   assign rsp_result_0  = result[0];
   assign rsp_result_1  = result[1];
   assign rsp_result_2  = result[2];
   assign rsp_result_3  = result[3];
   assign rsp_minimum_0 = minimum[0];
   assign rsp_minimum_1 = minimum[1];
   assign rsp_minimum_2 = minimum[2];
   assign rsp_minimum_3 = minimum[3];
   assign rsp_maximum_0 = maximum[0];
   assign rsp_maximum_1 = maximum[1];
   assign rsp_maximum_2 = maximum[2];
   assign rsp_maximum_3 = maximum[3];

endmodule

// File: rtl/smt_checker.sv
`timescale 1ns / 1ps
`include "spectral_matrix_transform_assert.svh"

module smt_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input smt_pkg::res_type              rsp_result_0,
   input smt_pkg::res_type              rsp_result_1,
   input smt_pkg::res_type              rsp_result_2,
   input smt_pkg::res_type              rsp_result_3,
   input smt_pkg::res_type              rsp_minimum_0,
   input smt_pkg::res_type              rsp_minimum_1,
   input smt_pkg::res_type              rsp_minimum_2,
   input smt_pkg::res_type              rsp_minimum_3,
   input smt_pkg::res_type              rsp_maximum_0,
   input smt_pkg::res_type              rsp_maximum_1,
   input smt_pkg::res_type              rsp_maximum_2,
   input smt_pkg::res_type              rsp_maximum_3
);
   import smt_pkg::*;

   logic                   stats_ok;
   logic [12*RES_W-1:0]    rsp_payload;

   assign stats_ok = (rsp_minimum_0 <= rsp_result_0) && (rsp_result_0 <= rsp_maximum_0)
                  && (rsp_minimum_1 <= rsp_result_1) && (rsp_result_1 <= rsp_maximum_1)
                  && (rsp_minimum_2 <= rsp_result_2) && (rsp_result_2 <= rsp_maximum_2)
                  && (rsp_minimum_3 <= rsp_result_3) && (rsp_result_3 <= rsp_maximum_3);

   assign rsp_payload = {rsp_result_0, rsp_result_1, rsp_result_2, rsp_result_3,
                         rsp_minimum_0, rsp_minimum_1, rsp_minimum_2, rsp_minimum_3,
                         rsp_maximum_0, rsp_maximum_1, rsp_maximum_2, rsp_maximum_3};

   // every reported result lies inside its own band's statistics
   `SMT_ASSERT_IMPLY(a_stats_bound, rsp_valid, stats_ok)

   // an accepted pixel with a free result side shows up as a valid result
   `SMT_ASSERT_NEXT(a_latency, (req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall, rsp_valid)

   `SMT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)

   `SMT_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp_payload))

endmodule

bind spectral_matrix_transform smt_checker u_smt_checker (.*);
